@@ rtl/sact_pkg.sv @@
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types, register codes and default sizes of the cache tag lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

    // default geometry
    localparam int DEF_WAYS      = 4;
    localparam int DEF_SETS      = 64;
    localparam int DEF_AGE_WIDTH = 16;

    // stream payload widths
    localparam int ADDR_W    = 64;
    localparam int CNT_W     = 32;
    localparam int OUT_W     = 2 + 1 + 2 + 3 * CNT_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;
    localparam int OUT_DW    = OUT_BYTES * 8;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [3:0] OFFSET_RESET = 4'd5;

    typedef struct packed {
        logic       policy;
        logic [3:0] offset_bits;
    } t_cfg;

    // per-way status from the shared compare unit
    typedef struct packed {
        logic match;
        logic invalid;
        logic older;
    } t_way_flags;

endpackage

`default_nettype wire

@@ rtl/sact_apb_regs.sv @@
// ----------------------------------------------------------------------------
// sact_apb_regs
// Configuration registers behind an APB-style port: policy and offset size.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_apb_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [sact_pkg::APB_AW-1:0]  paddr,
    input  wire  [sact_pkg::APB_DW-1:0]  pwdata,
    output logic [sact_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output sact_pkg::t_cfg               o_cfg
);
    import sact_pkg::*;

    t_cfg r_cfg;
    logic w_en;
    logic reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign w_en    = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy      <= POLICY_LRU;
            r_cfg.offset_bits <= OFFSET_RESET;
        end else if (w_en) begin
            case (reg_idx)
                REG_POLICY: r_cfg.policy      <= pwdata[0];
                REG_OFFSET: r_cfg.offset_bits <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POLICY: prdata = {{(APB_DW-1){1'b0}}, r_cfg.policy};
            REG_OFFSET: prdata = {{(APB_DW-4){1'b0}}, r_cfg.offset_bits};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/sact_way_unit.sv @@
// ----------------------------------------------------------------------------
// sact_way_unit
// Shared per-way unit: tag compare, saturating age step and age ranking.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_way_unit #(
    parameter int TAG_W = 58,
    parameter int AGE_W = 16
) (
    input  wire  [TAG_W-1:0]         i_line_tag,
    input  wire                      i_line_valid,
    input  wire  [TAG_W-1:0]         i_req_tag,
    input  wire  [AGE_W-1:0]         i_age,
    input  wire  [AGE_W-1:0]         i_top,
    output logic [AGE_W-1:0]         o_aged,
    output sact_pkg::t_way_flags     o_flags
);
    import sact_pkg::*;

    // saturate at all ones
    assign o_aged = (i_age != {AGE_W{1'b1}}) ? i_age + AGE_W'(1) : i_age;

    assign o_flags.match   = i_line_valid && (i_line_tag == i_req_tag);
    assign o_flags.invalid = !i_line_valid;
    assign o_flags.older   = o_aged > i_top;

endmodule

`default_nettype wire

@@ rtl/set_assoc_cache_tag_lookup.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag-only set-associative write-back, write-allocate cache with LRU or FIFO
// replacement and running hit, miss and writeback counts.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tdata carries the 64-bit byte address, s_tuser the access
//   kind (0 read, 1 write). Master stream: one result item per access with
//   outcome, victim dirty flag, way and the three running counts.
//   APB port: register 0 (addr 0) replacement policy, register 1 (addr 4)
//   offset bits. Write it only while the block is idle.
// Sequence:
//   An accepted item goes through a set-row read from the tag memory, a scan
//   of the ways one at a time through the shared compare unit, and a fill
//   that writes the row back and loads the result register. The next item is
//   taken only when the sequencer returns to idle after the fill.
// Reset:
//   Clears the per-set row-valid flops (all lines invalid, FIFO pointers at
//   zero), the counters and the registers; no clearing pass is needed.
// Stall:
//   A result waits in the output register while the next item is worked on;
//   write-back of that next item holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_lookup #(
    parameter int WAYS      = sact_pkg::DEF_WAYS,
    parameter int SETS      = sact_pkg::DEF_SETS,
    parameter int AGE_WIDTH = sact_pkg::DEF_AGE_WIDTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // slave stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [sact_pkg::ADDR_W-1:0]  s_tdata,   // [63:0] address
    input  wire                          s_tuser,   // [0] action
    // master stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [1:0] outcome, [2] victim_dirty, [4:3] way_used, [36:5] hit_total,
    // [68:37] miss_total, [100:69] writeback_total, [103:101] zero
    output logic [sact_pkg::OUT_DW-1:0]  m_tdata,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [sact_pkg::APB_AW-1:0]  paddr,
    input  wire  [sact_pkg::APB_DW-1:0]  pwdata,
    output logic [sact_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import sact_pkg::*;

    localparam int IB     = $clog2(SETS + 1) - 1;
    localparam int ROWS   = 1 << IB;
    localparam int SET_W  = (IB > 0) ? IB : 1;
    localparam int TAG_W  = ADDR_W - IB;
    localparam int AGE_W  = AGE_WIDTH;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int PTR_W  = WAY_W;
    localparam int LINE_W = TAG_W + 2 + AGE_W;
    localparam int ROW_W  = WAYS * LINE_W + PTR_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_FILL = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_cfg   cfg;

    // request
    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    logic             r_write;

    // tag memory and row-valid flops
    logic [ROW_W-1:0] mem [ROWS];
    logic [ROWS-1:0]  r_row_ok;
    logic [ROW_W-1:0] r_rd_row;
    logic             r_rd_ok;

    // scan state
    logic [WAY_W-1:0] r_way;
    logic             r_hit;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_inv_found;
    logic [WAY_W-1:0] r_inv_way;
    logic [WAY_W-1:0] r_best;
    logic [AGE_W-1:0] r_top;
    logic [AGE_W-1:0] r_w_age   [WAYS];
    logic             r_w_dirty [WAYS];

    // counters and output
    logic [CNT_W-1:0] r_hit_cnt, r_miss_cnt, r_wb_cnt;
    logic [CNT_W-1:0] n_hit_cnt, n_miss_cnt, n_wb_cnt;
    logic             r_out_valid;
    logic [OUT_DW-1:0] r_out_data;

    // input split
    logic [ADDR_W-1:0] addr_set_sh;
    logic [ADDR_W-1:0] addr_tag_sh;
    logic [SET_W-1:0]  in_set;

    // current way
    logic [LINE_W-1:0] cur_line;
    logic [TAG_W-1:0]  cur_tag;
    logic              cur_valid;
    logic              cur_dirty;
    logic [AGE_W-1:0]  cur_age;
    logic [AGE_W-1:0]  aged;
    t_way_flags        flags;
    logic              last_way;

    // fill
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  next_ptr;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  way_sel;
    logic              vd;
    logic [ROW_W-1:0]  wr_row;
    logic              accept;
    logic              fill_go;

    sact_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign fill_go  = (r_state == S_FILL) && (!r_out_valid || m_tready);

    assign addr_set_sh = s_tdata >> cfg.offset_bits;
    assign addr_tag_sh = s_tdata >> (6'(cfg.offset_bits) + 6'(IB));

    always_comb begin
        if (IB > 0) begin
            in_set = addr_set_sh[SET_W-1:0];
        end else begin
            in_set = '0;
        end
    end

    // line layout from the low bit: age, dirty, valid, tag
    assign cur_line  = r_rd_row[r_way*LINE_W +: LINE_W];
    assign cur_age   = cur_line[AGE_W-1:0];
    assign cur_valid = cur_line[AGE_W+1] & r_rd_ok;
    assign cur_dirty = cur_line[AGE_W] & cur_valid;
    assign cur_tag   = cur_line[LINE_W-1 -: TAG_W];
    assign last_way  = (r_way == WAY_W'(WAYS - 1));

    sact_way_unit #(
        .TAG_W (TAG_W),
        .AGE_W (AGE_W)
    ) u_way (
        .i_line_tag   (cur_tag),
        .i_line_valid (cur_valid),
        .i_req_tag    (r_tag),
        .i_age        (cur_age),
        .i_top        (r_top),
        .o_aged       (aged),
        .o_flags      (flags)
    );

    // victim and row to write back
    assign rd_ptr   = r_rd_ok ? r_rd_row[ROW_W-1 -: PTR_W] : '0;
    assign next_ptr = (rd_ptr == PTR_W'(WAYS - 1)) ? '0 : rd_ptr + PTR_W'(1);

    always_comb begin
        if (cfg.policy == POLICY_FIFO) begin
            victim = rd_ptr;
        end else if (r_inv_found) begin
            victim = r_inv_way;
        end else begin
            victim = r_best;
        end
        way_sel = r_hit ? r_hit_way : victim;
        vd      = !r_hit && r_w_dirty[victim];
    end

    always_comb begin
        wr_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            logic [LINE_W-1:0] ln;
            ln = r_rd_row[w*LINE_W +: LINE_W];
            ln[AGE_W+1]   = ln[AGE_W+1] & r_rd_ok;
            ln[AGE_W]     = r_w_dirty[w];
            ln[AGE_W-1:0] = r_w_age[w];
            if (!r_hit && (victim == WAY_W'(w))) begin
                ln = {r_tag, 1'b1, r_write, {AGE_W{1'b0}}};
            end
            wr_row[w*LINE_W +: LINE_W] = ln;
        end
        wr_row[ROW_W-1 -: PTR_W] = (!r_hit && cfg.policy == POLICY_FIFO) ? next_ptr : rd_ptr;
    end

    always_comb begin
        n_hit_cnt  = r_hit_cnt  + CNT_W'(r_hit);
        n_miss_cnt = r_miss_cnt + CNT_W'(!r_hit);
        n_wb_cnt   = r_wb_cnt   + CNT_W'(vd);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: n_state = S_SCAN;
            S_SCAN: if (last_way) n_state = S_FILL;
            S_FILL: if (fill_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory: one read, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_row <= mem[r_set];
        end
        if (fill_go) begin
            mem[r_set] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_ok    <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_wb_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fill_go) begin
                r_row_ok[r_set] <= 1'b1;
                r_hit_cnt       <= n_hit_cnt;
                r_miss_cnt      <= n_miss_cnt;
                r_wb_cnt        <= n_wb_cnt;
                r_out_valid     <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag       <= addr_tag_sh[TAG_W-1:0];
            r_set       <= in_set;
            r_write     <= s_tuser;
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_hit_way   <= '0;
            r_inv_found <= 1'b0;
            r_inv_way   <= '0;
            r_best      <= '0;
            r_top       <= '0;
        end
        if (r_state == S_READ) begin
            r_rd_ok <= r_row_ok[r_set];
        end
        if (r_state == S_SCAN) begin
            r_w_age[r_way]   <= flags.match ? '0 : aged;
            r_w_dirty[r_way] <= cur_dirty | (flags.match & (r_write == ACT_WRITE));
            if (flags.match) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_way;
            end
            // lowest invalid way wins, else first strictly oldest
            if (!r_inv_found) begin
                if (flags.invalid) begin
                    r_inv_found <= 1'b1;
                    r_inv_way   <= r_way;
                end else if (flags.older) begin
                    r_top  <= aged;
                    r_best <= r_way;
                end
            end
            if (!last_way) begin
                r_way <= r_way + WAY_W'(1);
            end
        end
        if (fill_go) begin
            r_out_data <= OUT_DW'({n_wb_cnt, n_miss_cnt, n_hit_cnt,
                                   2'(way_sel), vd, r_write, !r_hit});
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

`default_nettype wire
